FILE: hdl/fvwm_pkg.sv
package fvwm_pkg;

	localparam int TAB_BITS   = 10;
	localparam int FRAC_BITS  = 22;
	localparam int PHASE_W    = TAB_BITS + FRAC_BITS;
	localparam int NUM_VOICES = 5;
	localparam int QTR_BITS   = TAB_BITS - 2;
	localparam int QTR_SIZE   = 1 << QTR_BITS;

	localparam logic [15:0] AMPLITUDE = 16'd32760;

	// phase step reset values
	localparam logic [31:0] INC_ROOT_RST    = 32'd42852281;
	localparam logic [31:0] INC_THIRD_RST   = 32'd53565351;
	localparam logic [31:0] INC_FIFTH_RST   = 32'd64278422;
	localparam logic [31:0] INC_SEVENTH_RST = 32'd80348027;
	localparam logic [31:0] INC_NINTH_RST   = 32'd96417632;

	// temperature band edges, hottest last
	localparam logic [11:0] TEMP_THR_0 = 12'd2048;
	localparam logic [11:0] TEMP_THR_1 = 12'd1959;
	localparam logic [11:0] TEMP_THR_2 = 12'd1871;
	localparam logic [11:0] TEMP_THR_3 = 12'd1785;
	localparam logic [11:0] TEMP_THR_4 = 12'd1702;

	// fade-in divisors
	localparam logic [12:0] FADE_DIV_1 = 13'd89;
	localparam logic [12:0] FADE_DIV_2 = 13'd88;
	localparam logic [12:0] FADE_DIV_3 = 13'd86;
	localparam logic [12:0] FADE_DIV_4 = 13'd83;
	localparam logic [12:0] MIX_DIV    = 13'd5;
	localparam logic [12:0] LIGHT_FULL = 13'd4095;

	// floor(2^32 / d), exact quotient follows from one correction step
	localparam logic [31:0] RECIP_89   = 32'(33'h1_0000_0000 / 89);
	localparam logic [31:0] RECIP_88   = 32'(33'h1_0000_0000 / 88);
	localparam logic [31:0] RECIP_86   = 32'(33'h1_0000_0000 / 86);
	localparam logic [31:0] RECIP_83   = 32'(33'h1_0000_0000 / 83);
	localparam logic [31:0] RECIP_5    = 32'(33'h1_0000_0000 / 5);
	localparam logic [31:0] RECIP_4095 = 32'(33'h1_0000_0000 / 4095);

	// light bar edges
	localparam logic [11:0] LIGHT_THR_0 = 12'd3723;
	localparam logic [11:0] LIGHT_THR_1 = 12'd2482;
	localparam logic [11:0] LIGHT_THR_2 = 12'd1241;
	localparam logic [11:0] LIGHT_THR_3 = 12'd600;

	typedef enum logic [2:0] {
		REG_INC_ROOT    = 3'd0,
		REG_INC_THIRD   = 3'd1,
		REG_INC_FIFTH   = 3'd2,
		REG_INC_SEVENTH = 3'd3,
		REG_INC_NINTH   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_FADE_A,
		ST_FADE_B,
		ST_DIV_ABS,
		ST_DIV_MUL,
		ST_DIV_REM,
		ST_DIV_FIX,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIV_FADE,
		DIV_FIVE,
		DIV_LIGHT
	} div_kind_t;

	typedef logic [14:0] qtab_t [QTR_SIZE];

	// angle between neighboring table entries
	localparam real QTR_STEP = 2.0 * 3.14159265358979323846 / (4.0 * QTR_SIZE);

	// first quadrant of trunc(32760*sin), entry 0 up to just below 90 degrees
	function automatic qtab_t build_qtab();
		qtab_t tab;
		real   ang;
		real   val;
		for (int i = 0; i < QTR_SIZE; i++) begin
			ang = QTR_STEP * i;
			val = 32760.0 * $sin(ang);
			tab[i] = 15'($rtoi(val));
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

endpackage

FILE: hdl/fvwm_sine_rom.sv
module fvwm_sine_rom
	import fvwm_pkg::*;
(
	input  logic [TAB_BITS-1:0] index,
	output logic signed [15:0]  value
);

	logic [QTR_BITS-1:0] k;
	logic [QTR_BITS-1:0] k_mirror;
	logic [15:0]         mag;

	assign k        = index[QTR_BITS-1:0];
	assign k_mirror = QTR_BITS'(~k + 1'b1);

	// quarter wave: second half of each half-cycle reads mirrored
	always_comb begin
		if (index[QTR_BITS]) begin
			if (k == '0) begin
				mag = AMPLITUDE;
			end else begin
				mag = {1'b0, QTAB[k_mirror]};
			end
		end else begin
			mag = {1'b0, QTAB[k]};
		end
		value = index[TAB_BITS-1] ? -$signed(mag) : $signed(mag);
	end

endmodule

FILE: hdl/five_voice_wavetable_mixer.sv
// five-voice wavetable mixer
//
// input stream: one word per audio tick, tdata = temperature reading [11:0],
// light reading [23:12]. output stream: one word per input word, tdata =
// signed audio sample [15:0], temperature bar [18:16], light bar [21:19].
// config port: cfg_we writes cfg_data into phase step register cfg_index
// (0 root, 1 third, 2 fifth, 3 seventh, 4 ninth); other indexes are dropped.
// write only while no word is in flight.
//
// a word goes from accept to the result in the output register through the
// phase steps, the fade steps when a fade voice sounds, and the divisions;
// the next word is taken in the idle state after that. the cost comes from
// one shared multiply-accumulate unit: five phase/table steps, two fade
// products and the fade-divisor division with a fade voice, divisions by
// reciprocal multiply plus correction (5, 4095) and the light scaling.
// the output register frees the core: a stalled receiver only holds the
// finished word, and a new word is still taken but waits in its last step
// until that register can load.
// reset clears phases, held temperature bar and output valid, and loads the
// default phase steps.
module five_voice_wavetable_mixer
	import fvwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // temperature_reading[11:0], light_reading[23:12]
	// output words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // audio_sample[15:0], temperature_bar[18:16],
	                                   // light_bar[21:19], zero[23:22]
);

	state_t    state_q, state_nxt;
	div_kind_t kind_q;

	logic [31:0]        inc_q [NUM_VOICES];
	logic [PHASE_W-1:0] phase_q [NUM_VOICES];
	logic [2:0]         voice_q;
	logic [11:0]        temp_q;
	logic [11:0]        light_q;
	logic [2:0]         held_bar_q;

	logic signed [18:0] sum_q;
	logic signed [15:0] sel_q;
	logic signed [18:0] val_q;
	logic signed [63:0] prod_q;
	logic [27:0]        mag_q;
	logic               neg_q;
	logic [27:0]        quo_q;

	logic               m_valid_q;
	logic [23:0]        m_data_q;

	// phase step and table read for the current voice
	logic [PHASE_W-1:0] phase_nxt;
	logic signed [15:0] sine_val;
	logic               last_voice;

	// band decode
	logic [2:0]  full;
	logic [11:0] fade_thr;
	logic [12:0] fade_div;
	logic [6:0]  fade_w;
	logic        fade_band;

	// shared multiply-accumulate
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [63:0] mul_add;
	logic signed [65:0] mul_full;

	logic [12:0]        div_d;
	logic [31:0]        div_recip;
	logic signed [63:0] div_src;
	logic signed [63:0] div_abs;
	logic [28:0]        quo_fix;
	logic signed [28:0] quo_signed;
	logic signed [18:0] sum_nxt;
	logic [2:0]         light_bar;
	logic [12:0]        light_gain;
	logic               out_free;

	assign phase_nxt  = phase_q[voice_q] + inc_q[voice_q];
	assign last_voice = (voice_q == 3'(NUM_VOICES - 1));

	fvwm_sine_rom u_rom (
		.index (phase_nxt[PHASE_W-1 -: TAB_BITS]),
		.value (sine_val)
	);

	// number of fully sounding voices, 5 at the hottest band
	always_comb begin
		if (temp_q > TEMP_THR_0) begin
			full = 3'd0;
		end else if (temp_q > TEMP_THR_1) begin
			full = 3'd1;
		end else if (temp_q > TEMP_THR_2) begin
			full = 3'd2;
		end else if (temp_q > TEMP_THR_3) begin
			full = 3'd3;
		end else if (temp_q > TEMP_THR_4) begin
			full = 3'd4;
		end else begin
			full = 3'd5;
		end
	end

	always_comb begin
		case (full)
			3'd1: begin
				fade_thr = TEMP_THR_0;
				fade_div = FADE_DIV_1;
			end
			3'd2: begin
				fade_thr = TEMP_THR_1;
				fade_div = FADE_DIV_2;
			end
			3'd3: begin
				fade_thr = TEMP_THR_2;
				fade_div = FADE_DIV_3;
			end
			3'd4: begin
				fade_thr = TEMP_THR_3;
				fade_div = FADE_DIV_4;
			end
			default: begin
				fade_thr = TEMP_THR_0;
				fade_div = FADE_DIV_1;
			end
		endcase
	end

	assign fade_band = (full != 3'd0) && (full != 3'd5);
	assign fade_w    = 7'(fade_thr - temp_q);

	// divisor and reciprocal for the division in progress
	always_comb begin
		case (kind_q)
			DIV_FADE: begin
				div_d = fade_div;
				case (full)
					3'd2:    div_recip = RECIP_88;
					3'd3:    div_recip = RECIP_86;
					3'd4:    div_recip = RECIP_83;
					default: div_recip = RECIP_89;
				endcase
			end
			DIV_FIVE: begin
				div_d     = MIX_DIV;
				div_recip = RECIP_5;
			end
			DIV_LIGHT: begin
				div_d     = LIGHT_FULL;
				div_recip = RECIP_4095;
			end
			default: begin
				div_d     = MIX_DIV;
				div_recip = RECIP_5;
			end
		endcase
	end

	// fade and light divisions take the product, the divide by 5 takes the mix
	assign div_src    = (kind_q == DIV_FIVE) ? 64'(val_q) : prod_q;
	assign div_abs    = div_src[63] ? -div_src : div_src;
	assign quo_fix    = (prod_q >= $signed({51'd0, div_d})) ? {1'b0, quo_q} + 29'd1
	                                                        : {1'b0, quo_q};
	assign quo_signed = neg_q ? -$signed(quo_fix) : $signed(quo_fix);
	assign sum_nxt    = (voice_q < full) ? sum_q + 19'(sine_val) : sum_q;
	assign light_gain = LIGHT_FULL - {1'b0, light_q};
	assign out_free   = !m_valid_q || m_axis_tready;

	always_comb begin
		if (light_q > LIGHT_THR_0) begin
			light_bar = 3'd0;
		end else if (light_q > LIGHT_THR_1) begin
			light_bar = 3'd1;
		end else if (light_q > LIGHT_THR_2) begin
			light_bar = 3'd2;
		end else if (light_q > LIGHT_THR_3) begin
			light_bar = 3'd3;
		end else begin
			light_bar = 3'd4;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = ST_PHASE;
				end
			end
			ST_PHASE: begin
				if (last_voice) begin
					state_nxt = fade_band ? ST_FADE_A : ST_DIV_ABS;
				end
			end
			ST_FADE_A:  state_nxt = ST_FADE_B;
			ST_FADE_B:  state_nxt = ST_DIV_ABS;
			ST_DIV_ABS: state_nxt = ST_DIV_MUL;
			ST_DIV_MUL: state_nxt = ST_DIV_REM;
			ST_DIV_REM: state_nxt = ST_DIV_FIX;
			ST_DIV_FIX: begin
				case (kind_q)
					DIV_FADE:  state_nxt = ST_DIV_ABS;
					DIV_FIVE:  state_nxt = ST_SCALE;
					DIV_LIGHT: state_nxt = ST_DONE;
					default:   state_nxt = ST_DONE;
				endcase
			end
			ST_SCALE:   state_nxt = ST_DIV_ABS;
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and multiplier operands
	always_comb begin
		s_axis_tready = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		mul_add       = '0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_FADE_A: begin
				mul_a = 33'(sum_q);
				mul_b = $signed({20'd0, fade_div});
			end
			ST_FADE_B: begin
				mul_a   = $signed({26'd0, fade_w});
				mul_b   = 33'(sel_q);
				mul_add = prod_q;
			end
			ST_DIV_MUL: begin
				mul_a = $signed({5'd0, mag_q});
				mul_b = $signed({1'b0, div_recip});
			end
			ST_DIV_REM: begin
				// remainder = dividend - estimate * divisor
				mul_a   = $signed({5'd0, prod_q[59:32]});
				mul_b   = -$signed({20'd0, div_d});
				mul_add = $signed({36'd0, mag_q});
			end
			ST_SCALE: begin
				mul_a = 33'(val_q);
				mul_b = $signed({20'd0, light_gain});
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= DIV_FIVE;
			voice_q    <= '0;
			held_bar_q <= '0;
			m_valid_q  <= 1'b0;
			inc_q[0]   <= INC_ROOT_RST;
			inc_q[1]   <= INC_THIRD_RST;
			inc_q[2]   <= INC_FIFTH_RST;
			inc_q[3]   <= INC_SEVENTH_RST;
			inc_q[4]   <= INC_NINTH_RST;
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_q[v] <= '0;
			end
		end else begin
			state_q <= state_nxt;

			if (cfg_we) begin
				case (cfg_index)
					REG_INC_ROOT:    inc_q[0] <= cfg_data;
					REG_INC_THIRD:   inc_q[1] <= cfg_data;
					REG_INC_FIFTH:   inc_q[2] <= cfg_data;
					REG_INC_SEVENTH: inc_q[3] <= cfg_data;
					REG_INC_NINTH:   inc_q[4] <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: voice_q <= '0;
				ST_PHASE: begin
					phase_q[voice_q] <= phase_nxt;
					voice_q          <= voice_q + 3'd1;
					if (last_voice) begin
						kind_q <= fade_band ? DIV_FADE : DIV_FIVE;
						if (full != 3'd5) begin
							held_bar_q <= full;
						end
					end
				end
				ST_DIV_FIX: begin
					if (kind_q == DIV_FADE) begin
						kind_q <= DIV_FIVE;
					end
				end
				ST_SCALE: kind_q <= DIV_LIGHT;
				default: ;
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= $signed(mul_full[63:0]) + mul_add;

		case (state_q)
			ST_IDLE: begin
				temp_q  <= s_axis_tdata[11:0];
				light_q <= s_axis_tdata[23:12];
				sum_q   <= '0;
			end
			ST_PHASE: begin
				sum_q <= sum_nxt;
				if (voice_q == full) begin
					sel_q <= sine_val;
				end
				if (last_voice) begin
					// no fade: lone root voice or the full chord
					val_q <= (full == 3'd0) ? 19'(sel_q) : sum_nxt;
				end
			end
			ST_DIV_ABS: begin
				mag_q <= div_abs[27:0];
				neg_q <= div_src[63];
			end
			ST_DIV_REM: quo_q <= prod_q[59:32];
			ST_DIV_FIX: val_q <= quo_signed[18:0];
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {2'b00, light_bar, held_bar_q, val_q[15:0]};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

FILE: tb/fvwm_checker.sv
module fvwm_checker
	import fvwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // temperature_reading[11:0], light_reading[23:12]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // audio_sample[15:0], temperature_bar[18:16],
	                                    // light_bar[21:19], zero[23:22]
	output int          fail_count,
	output int          outstanding,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_LEN = 1024;
	localparam int          PEAK      = 32760;
	localparam logic [63:0] PI_FIX    = 64'h3243F6A8885A308D;   // pi in q60

	localparam logic [31:0] ROOT_DEFAULT    = 32'd42852281;
	localparam logic [31:0] THIRD_DEFAULT   = 32'd53565351;
	localparam logic [31:0] FIFTH_DEFAULT   = 32'd64278422;
	localparam logic [31:0] SEVENTH_DEFAULT = 32'd80348027;
	localparam logic [31:0] NINTH_DEFAULT   = 32'd96417632;

	typedef struct packed {
		logic signed [15:0] audio;
		logic [2:0]         temp_lamps;
		logic [2:0]         light_lamps;
	} mix_word_t;

	int          sine_rom [TABLE_LEN];
	logic [31:0] acc [5];
	logic [31:0] step_size [5];
	logic [2:0]  lamp_hold;
	mix_word_t   expected_words [$];
	int          errors;
	int          checked;

	assign fail_count    = errors;
	assign words_checked = checked;

	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// exact truncation of PEAK*sin(2*pi*i/TABLE_LEN), fixed-point taylor series
	function automatic int sine_value(input int unsigned i);
		logic [63:0] twopi, th, x2, term, total, mag, a;
		int unsigned j;
		bit          neg;
		twopi = PI_FIX * 2;
		a = 64'(12 * i);
		neg = 1'b0;
		if (a % TABLE_LEN == 0) begin
			j = (a / TABLE_LEN) % 12;
			case (j)
				0, 6: return 0;
				1, 5: return PEAK / 2;
				3: return PEAK;
				7, 11: return -(PEAK / 2);
				9: return -PEAK;
				default: ;
			endcase
		end
		th = (twopi / TABLE_LEN) * i + ((twopi % TABLE_LEN) * i) / TABLE_LEN;
		if (th >= PI_FIX) begin
			th = th - PI_FIX;
			neg = 1'b1;
		end
		if (th > (PI_FIX >> 1))
			th = PI_FIX - th;
		x2 = q60_mul(th, th);
		term = th;
		total = th;
		for (int k = 1; k < 20 && term != 0; k++) begin
			term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				total = total - term;
			else
				total = total + term;
		end
		mag = q60_mul(64'(PEAK), total);
		if (mag > PEAK)
			mag = PEAK;
		return neg ? -int'(mag) : int'(mag);
	endfunction

	function automatic int band_edge(input int b);
		case (b)
			0: return 2048;
			1: return 1959;
			2: return 1871;
			3: return 1785;
			default: return 1702;
		endcase
	endfunction

	function automatic int fade_div(input int voices);
		case (voices)
			1: return 89;
			2: return 88;
			3: return 86;
			default: return 83;
		endcase
	endfunction

	// advances the five phases and works out the word for one tick
	function automatic mix_word_t mix_tick(input logic [11:0] temp, input logic [11:0] light);
		mix_word_t w;
		longint    s [5];
		longint    total, num, mixv, q, scaled, d;
		int        t, l, voices;
		t = temp;
		l = light;
		for (int v = 0; v < 5; v++) begin
			acc[v] = acc[v] + step_size[v];
			s[v] = sine_rom[acc[v][31:22]];
		end
		voices = 5;
		for (int b = 4; b >= 0; b--)
			if (t > band_edge(b))
				voices = b;
		total = 0;
		if (voices == 0) begin
			mixv = s[0];
		end else if (voices == 5) begin
			for (int v = 0; v < 5; v++)
				total += s[v];
			mixv = total;
		end else begin
			d = fade_div(voices);
			for (int v = 0; v < voices; v++)
				total += s[v];
			num = total * d + longint'(band_edge(voices - 1) - t) * s[voices];
			mixv = num / d;
		end
		// hottest band keeps the last lamp count
		if (voices < 5)
			lamp_hold = 3'(voices);
		q = mixv / 5;
		scaled = (q * longint'(4095 - l)) / 4095;
		w.audio = 16'(scaled);
		w.temp_lamps = lamp_hold;
		if (l > 3723)
			w.light_lamps = 3'd0;
		else if (l > 2482)
			w.light_lamps = 3'd1;
		else if (l > 1241)
			w.light_lamps = 3'd2;
		else if (l > 600)
			w.light_lamps = 3'd3;
		else
			w.light_lamps = 3'd4;
		return w;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
		end
	endtask

	initial begin
		for (int i = 0; i < TABLE_LEN; i++)
			sine_rom[i] = sine_value(i);
	end

	always @(posedge clk or negedge arst_n) begin : watch
		mix_word_t want;
		if (!arst_n) begin
			for (int v = 0; v < 5; v++)
				acc[v] = '0;
			step_size[0] = ROOT_DEFAULT;
			step_size[1] = THIRD_DEFAULT;
			step_size[2] = FIFTH_DEFAULT;
			step_size[3] = SEVENTH_DEFAULT;
			step_size[4] = NINTH_DEFAULT;
			lamp_hold = '0;
			expected_words.delete();
			errors = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INC_ROOT:    step_size[0] = cfg_data;
					REG_INC_THIRD:   step_size[1] = cfg_data;
					REG_INC_FIFTH:   step_size[2] = cfg_data;
					REG_INC_SEVENTH: step_size[3] = cfg_data;
					REG_INC_NINTH:   step_size[4] = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(mix_tick(s_axis_tdata[11:0], s_axis_tdata[23:12]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: output word %h with nothing expected", $realtime,
							m_axis_tdata);
				end else begin
					want = expected_words.pop_front();
					checked++;
					check_field("audio_sample", int'(want.audio), int'($signed(m_axis_tdata[15:0])));
					check_field("temperature_bar", int'(want.temp_lamps), int'(m_axis_tdata[18:16]));
					check_field("light_bar", int'(want.light_lamps), int'(m_axis_tdata[21:19]));
					check_field("pad bits", 0, int'(m_axis_tdata[23:22]));
				end
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

FILE: tb/tb_five_voice_wavetable_mixer.sv
// stimulus and verdict for the five-voice wavetable mixer; all checking lives in
// fvwm_checker, which sits on the same wires as the block
module tb_five_voice_wavetable_mixer;
	import fvwm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS_PER_PHASE = 240;
	localparam int NUM_PHASES      = 8;
	localparam int CYCLE_LIMIT     = 800000;
	localparam int SETTLE_CYCLES   = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;      // temperature_reading[11:0], light_reading[23:12]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // audio_sample[15:0], temperature_bar[18:16],
	                                     // light_bar[21:19], zero[23:22]

	int          tx_idle_pct = 0;        // chance the sender holds off in a given cycle
	int          rx_stall_pct = 0;       // chance the receiver stalls in a given cycle
	int          words_sent = 0;
	int          cycles = 0;
	logic [31:0] step_plan [5];          // phase steps for the next register load

	int          fail_count;
	int          outstanding;
	int          words_checked;

	five_voice_wavetable_mixer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	fvwm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	always #10 clk = ~clk;

	// receiver side: random stalls per cycle
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// one word per call; random idle cycles in front, then hold until taken
	task automatic feed_reading(input logic [11:0] temp, input logic [11:0] light);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {light, temp};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// drain: every expected word back, then a margin so the block is surely idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes step_plan into the five step registers, back to back;
	// optionally also pokes the unused indexes with junk, which must be dropped
	task automatic load_steps(input bit with_unused);
		int top_index;
		top_index = with_unused ? (1 << $bits(cfg_index)) - 1 : REG_INC_NINTH;
		for (int r = REG_INC_ROOT; r <= top_index; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data  <= (r <= REG_INC_NINTH) ? step_plan[r] : $urandom();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// temperatures bunch around the band edges, where the fades happen
	function automatic logic [11:0] pick_temp();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 12'($urandom_range(2150, 1650));
		if (r < 70) begin
			case ($urandom_range(4))
				0: return TEMP_THR_0 + 12'($urandom_range(2)) - 12'd1;
				1: return TEMP_THR_1 + 12'($urandom_range(2)) - 12'd1;
				2: return TEMP_THR_2 + 12'($urandom_range(2)) - 12'd1;
				3: return TEMP_THR_3 + 12'($urandom_range(2)) - 12'd1;
				default: return TEMP_THR_4 + 12'($urandom_range(2)) - 12'd1;
			endcase
		end
		return 12'($urandom_range(4095));
	endfunction

	function automatic logic [11:0] pick_light();
		if ($urandom_range(99) < 80)
			return 12'($urandom_range(4095));
		case ($urandom_range(3))
			0: return LIGHT_THR_0 + 12'($urandom_range(1));
			1: return LIGHT_THR_1 + 12'($urandom_range(1));
			2: return LIGHT_THR_2 + 12'($urandom_range(1));
			default: return LIGHT_THR_3 + 12'($urandom_range(1));
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hottest band right after reset shows the held zero, then
		// both sides of every temperature and light edge, extremes of both fields
		feed_reading(12'd0, 12'd0);
		feed_reading(12'd4095, 12'd4095);
		feed_reading(12'd2049, 12'd3723);
		feed_reading(12'd2048, 12'd3724);
		feed_reading(12'd2000, 12'd2482);
		feed_reading(12'd1960, 12'd2483);
		feed_reading(12'd1959, 12'd1241);
		feed_reading(12'd1900, 12'd1242);
		feed_reading(12'd1872, 12'd600);
		feed_reading(12'd1871, 12'd601);
		feed_reading(12'd1800, 12'd1000);
		feed_reading(12'd1786, 12'd2000);
		feed_reading(12'd1785, 12'd3000);
		feed_reading(12'd1750, 12'd100);
		feed_reading(12'd1703, 12'd4000);
		feed_reading(12'd1702, 12'd0);       // hottest band, holds four lamps
		feed_reading(12'd1000, 12'd4095);
		feed_reading(12'd1500, 12'd0);
		feed_reading(12'd2500, 12'd0);
		feed_reading(12'd1702, 12'd50);      // hottest band, holds zero lamps
		feed_reading(12'd1703, 12'd50);
		feed_reading(12'd0, 12'd4094);
		feed_reading(12'hAAA, 12'h555);
		feed_reading(12'h555, 12'hAAA);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			// step settings: reset values first and last, in between the extremes and random mixes
			case (p)
				0: ;
				1: for (int v = 0; v < 5; v++) step_plan[v] = '0;
				2: for (int v = 0; v < 5; v++) step_plan[v] = '1;
				3, 6: for (int v = 0; v < 5; v++) step_plan[v] = $urandom();
				4: for (int v = 0; v < 5; v++) step_plan[v] = $urandom_range(32'h0040_0000);
				5: begin
					// whole table steps, one voice at half a turn
					for (int v = 0; v < 5; v++) step_plan[v] = $urandom() & 32'hFFC0_0000;
					step_plan[2] = 32'h8000_0000;
				end
				default: begin
					step_plan[0] = INC_ROOT_RST;
					step_plan[1] = INC_THIRD_RST;
					step_plan[2] = INC_FIFTH_RST;
					step_plan[3] = INC_SEVENTH_RST;
					step_plan[4] = INC_NINTH_RST;
				end
			endcase
			if (p != 0)
				load_steps(p == 6);
			// flow control: none, sender gaps, receiver stalls, both
			case (p % 4)
				0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
				1: begin tx_idle_pct <= 61; rx_stall_pct <= 0;  end
				2: begin tx_idle_pct <= 0;  rx_stall_pct <= 61; end
				default: begin tx_idle_pct <= 20; rx_stall_pct <= 20; end
			endcase
			@(posedge clk);
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				feed_reading(pick_temp(), pick_light());
		end

		settle();
		$display("covered %0d input words and %0d checked output words", words_sent,
			words_checked);
		$display("over %0d phase step settings with gaps and stalls on both sides",
			NUM_PHASES);
		if (fail_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
hdl/fvwm_pkg.sv
hdl/fvwm_sine_rom.sv
hdl/five_voice_wavetable_mixer.sv
tb/fvwm_checker.sv
tb/tb_five_voice_wavetable_mixer.sv
